/* rtl/core/dcwp_pkg.sv */
// Shared types and constants for the draw-command word parser.
// Used by the front, queue, back and top level modules; no dependencies.
package dcwp_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NUM_OPS = 8;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  // Record kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_RECT   = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // End-of-message status codes
  localparam logic [2:0] ST_STOP      = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_SOURCE    = 3'd4;
  localparam logic [2:0] ST_MAGIC     = 3'd5;
  localparam logic [2:0] ST_SHORT     = 3'd6;

  // Opcode words
  localparam logic [WORD_W-1:0] OP_RECT = 32'd1;
  localparam logic [WORD_W-1:0] OP_LINE = 32'd2;
  localparam logic [WORD_W-1:0] OP_STOP = 32'd255;

  // Header length in words (magic, version, five clear words)
  localparam logic [3:0] HEADER_WORDS = 4'd7;
  localparam logic [3:0] RECT_OPS     = 4'd7;
  localparam logic [3:0] LINE_OPS     = 4'd8;
  localparam logic [3:0] CLEAR_OPS    = 4'd5;

  // Configuration register indexes and reset values
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_MAGIC  = 1'b1;
  localparam logic [7:0]        SOURCE_RESET = 8'd1;
  localparam logic [WORD_W-1:0] MAGIC_RESET  = 32'h4546_5231;

  // Results caused by one accepted word: an optional record, then an
  // optional status record.
  typedef struct packed {
    logic                          rec_valid;
    logic [1:0]                    rec_kind;
    logic [NUM_OPS-1:0][WORD_W-1:0] rec_ops;
    logic                          sts_valid;
    logic [2:0]                    sts_code;
  } entry_t;

endpackage

/* rtl/core/dcwp_front.sv */
// Front part of the draw-command word parser: framing, header and opcode
// decode, operand collection. Depends on dcwp_pkg.
module dcwp_front import dcwp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [WORD_W-1:0]    data_word,
  input  logic [7:0]           source_id,
  input  logic                 start_of_message,
  input  logic                 end_of_message,
  input  logic [7:0]           accepted_source,
  input  logic [WORD_W-1:0]    magic_value,
  output logic                 push,
  output entry_t               entry
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_OPCODE,
    PH_OPERANDS,
    PH_DRAIN
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [3:0]                    wc_r, wc_nxt;
  logic [1:0]                    op_r, op_nxt;
  logic [2:0]                    pend_r, pend_nxt;
  logic [NUM_OPS-1:0][WORD_W-1:0] opnd_r, opnd_nxt;

  phase_t     ph_start, ph_work;
  logic [3:0] wc_start, wc_inc, need, nops;
  logic [1:0] op_start;
  logic [2:0] pend_start, pend_work, sts_code;
  logic       rec_valid;
  logic [1:0] rec_kind;
  logic [3:0] wc_work;
  logic [1:0] op_work;

  always_comb begin
    // Start mark resets the parse, whatever was in progress
    ph_start   = phase_r;
    wc_start   = wc_r;
    op_start   = op_r;
    pend_start = pend_r;
    if (start_of_message) begin
      wc_start = 4'd0;
      op_start = 2'd0;
      if (source_id != accepted_source) begin
        ph_start   = PH_DRAIN;
        pend_start = ST_SOURCE;
      end else begin
        ph_start   = PH_HEADER;
        pend_start = ST_STOP;
      end
    end

    ph_work   = ph_start;
    wc_work   = wc_start;
    op_work   = op_start;
    pend_work = pend_start;
    opnd_nxt  = opnd_r;
    rec_valid = 1'b0;
    rec_kind  = KIND_CLEAR;
    nops      = 4'd0;
    wc_inc    = wc_start + 4'd1;
    need      = (op_start == KIND_LINE) ? LINE_OPS : RECT_OPS;

    unique case (ph_start)
      PH_HEADER: begin
        if (wc_start == 4'd0 && data_word != magic_value) begin
          pend_work = ST_MAGIC;
        end
        if (wc_start >= 4'd2) begin
          opnd_nxt[3'(wc_start - 4'd2)] = data_word;
        end
        wc_work = wc_inc;
        if (wc_inc >= HEADER_WORDS) begin
          if (pend_work == ST_MAGIC) begin
            ph_work = PH_DRAIN;
          end else begin
            rec_valid = 1'b1;
            rec_kind  = KIND_CLEAR;
            nops      = CLEAR_OPS;
            ph_work   = PH_OPCODE;
          end
          wc_work = 4'd0;
        end
      end
      PH_OPCODE: begin
        if (data_word == OP_STOP) begin
          pend_work = ST_STOP;
          ph_work   = PH_DRAIN;
        end else if (data_word == OP_RECT || data_word == OP_LINE) begin
          op_work = data_word[1:0];
          wc_work = 4'd0;
          ph_work = PH_OPERANDS;
        end else begin
          pend_work = ST_UNKNOWN;
          ph_work   = PH_DRAIN;
        end
      end
      PH_OPERANDS: begin
        opnd_nxt[wc_start[2:0]] = data_word;
        wc_work = wc_inc;
        if (wc_inc >= need) begin
          rec_valid = 1'b1;
          rec_kind  = op_start;
          nops      = need;
          wc_work   = 4'd0;
          ph_work   = PH_OPCODE;
        end
      end
      PH_IDLE, PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    unique case (ph_work)
      PH_HEADER:   sts_code = ST_SHORT;
      PH_OPCODE:   sts_code = ST_EXHAUSTED;
      PH_OPERANDS: sts_code = ST_TRUNCATED;
      default: begin
        if (pend_work == ST_MAGIC && wc_work != 4'd0) begin
          sts_code = ST_SHORT;
        end else begin
          sts_code = pend_work;
        end
      end
    endcase

    phase_nxt = ph_work;
    wc_nxt    = wc_work;
    op_nxt    = op_work;
    pend_nxt  = pend_work;
    if (end_of_message && ph_start != PH_IDLE) begin
      phase_nxt = PH_IDLE;
      wc_nxt    = 4'd0;
      op_nxt    = 2'd0;
    end

    entry.rec_valid = rec_valid;
    entry.rec_kind  = rec_kind;
    for (int i = 0; i < NUM_OPS; i++) begin
      entry.rec_ops[i] = (4'(i) < nops) ? opnd_nxt[i] : '0;
    end
    entry.sts_valid = end_of_message && ph_start != PH_IDLE;
    entry.sts_code  = sts_code;

    push = accept && (entry.rec_valid || entry.sts_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wc_r    <= 4'd0;
      op_r    <= 2'd0;
      pend_r  <= ST_STOP;
    end else if (accept) begin
      phase_r <= phase_nxt;
      wc_r    <= wc_nxt;
      op_r    <= op_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Operand store holds payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      opnd_r <= opnd_nxt;
    end
  end

endmodule

/* rtl/core/dcwp_queue.sv */
// Short queue between the front and back parts of the parser.
// Holds the results of one word per entry. Depends on dcwp_pkg.
module dcwp_queue import dcwp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  entry_t         push_entry,
  input  logic           pop,
  output entry_t         head,
  output logic [QCW-1:0] count
);

  entry_t         slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign count = count_r;

endmodule

/* rtl/core/dcwp_back.sv */
// Back part of the parser: presents the head queue entry as one or two
// result words, record first, then status. Depends on dcwp_pkg.
module dcwp_back import dcwp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  entry_t                         head,
  input  logic                           head_valid,
  input  logic                           out_take,
  output logic                           q_pop,
  output logic [1:0]                     record_kind,
  output logic [2:0]                     end_status,
  output logic [NUM_OPS-1:0][WORD_W-1:0] operands,
  output logic                           last_of_run
);

  logic rec_done_r, rec_done_nxt;
  logic show_rec;

  always_comb begin
    show_rec = head.rec_valid && !rec_done_r;
    if (show_rec) begin
      record_kind = head.rec_kind;
      end_status  = ST_STOP;
      operands    = head.rec_ops;
      last_of_run = !head.sts_valid;
    end else begin
      record_kind = KIND_STATUS;
      end_status  = head.sts_code;
      operands    = '0;
      last_of_run = 1'b1;
    end

    // Hold the entry after its record while the status word is still due
    q_pop        = 1'b0;
    rec_done_nxt = rec_done_r;
    if (head_valid && out_take) begin
      if (show_rec && head.sts_valid) begin
        rec_done_nxt = 1'b1;
      end else begin
        q_pop        = 1'b1;
        rec_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_done_r <= 1'b0;
    end else begin
      rec_done_r <= rec_done_nxt;
    end
  end

endmodule

/* rtl/core/draw_command_word_parser_core.sv */
// Draw-command word parser: one message word in, clear/rect/line/status
// records out. Top level; uses dcwp_pkg, dcwp_front, dcwp_queue, dcwp_back.
//
// One message word is taken per clock while the four-entry result queue
// has room; in_full rises only when that queue is full. A word gives at
// most one draw record plus, on the end mark, one status record; such a
// word gives two result words, since the back part hands out one result
// word per pop. A result is on the out_ ports at the earliest the cycle
// after its word is taken, later when older results still wait. Words
// outside a message, and drained words after a stop, a bad source or a
// bad magic, give no draw record. Configuration writes are always ready
// and take effect on the next word.
module draw_command_word_parser_core import dcwp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_push,
  output logic              in_full,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic [7:0]        in_source_id,
  input  logic              in_start_of_message,
  input  logic              in_end_of_message,
  // results
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_record_kind,
  output logic [2:0]        out_end_status,
  output logic [WORD_W-1:0] out_operand_0,
  output logic [WORD_W-1:0] out_operand_1,
  output logic [WORD_W-1:0] out_operand_2,
  output logic [WORD_W-1:0] out_operand_3,
  output logic [WORD_W-1:0] out_operand_4,
  output logic [WORD_W-1:0] out_operand_5,
  output logic [WORD_W-1:0] out_operand_6,
  output logic [WORD_W-1:0] out_operand_7,
  output logic              out_last_of_run,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  logic [7:0]                     src_r;
  logic [WORD_W-1:0]              magic_r;
  logic                           in_accept;
  logic                           fe_push;
  entry_t                         fe_entry;
  entry_t                         q_head;
  logic [QCW-1:0]                 q_count;
  logic                           q_pop;
  logic [NUM_OPS-1:0][WORD_W-1:0] be_ops;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r   <= SOURCE_RESET;
      magic_r <= MAGIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE: src_r   <= cfg_data[7:0];
        CFG_MAGIC:  magic_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_full   = (q_count == QCW'(QDEPTH));
  assign in_accept = in_push && !in_full;
  assign out_empty = (q_count == '0);

  dcwp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .data_word        (in_data_word),
    .source_id        (in_source_id),
    .start_of_message (in_start_of_message),
    .end_of_message   (in_end_of_message),
    .accepted_source  (src_r),
    .magic_value      (magic_r),
    .push             (fe_push),
    .entry            (fe_entry)
  );

  dcwp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fe_push),
    .push_entry (fe_entry),
    .pop        (q_pop),
    .head       (q_head),
    .count      (q_count)
  );

  dcwp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .head_valid  (!out_empty),
    .out_take    (out_pop),
    .q_pop       (q_pop),
    .record_kind (out_record_kind),
    .end_status  (out_end_status),
    .operands    (be_ops),
    .last_of_run (out_last_of_run)
  );

  assign out_operand_0 = be_ops[0];
  assign out_operand_1 = be_ops[1];
  assign out_operand_2 = be_ops[2];
  assign out_operand_3 = be_ops[3];
  assign out_operand_4 = be_ops[4];
  assign out_operand_5 = be_ops[5];
  assign out_operand_6 = be_ops[6];
  assign out_operand_7 = be_ops[7];

  // A status word always closes the run of its input word
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_record_kind == KIND_STATUS) |-> out_last_of_run)
    else $error("status record not marked last of run");

  // Draw records carry no status code
  a_rec_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_record_kind != KIND_STATUS) |-> (out_end_status == ST_STOP))
    else $error("draw record with non-zero status");

  // A status entry is only raised by a word carrying the end mark
  a_status_on_eom: assert property (@(posedge clk) disable iff (!rst_n)
    (fe_push && fe_entry.sts_valid) |-> in_end_of_message)
    else $error("status entry without end mark");

  // Queue fill rises by one on a push without a pop
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fe_push && !q_pop) |=> (q_count == $past(q_count) + QCW'(1)))
    else $error("queue count did not advance on push");

endmodule
